FILE: src/pressure_report_trigger_macros.svh
// Assertion macros for the pressure report trigger.
`ifndef PRESSURE_REPORT_TRIGGER_MACROS_SVH
`define PRESSURE_REPORT_TRIGGER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk with rst_n held off
`define PRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRT_ASSERT_IMP(lbl, ante, cons, msg)
`define PRT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/prt_pkg.sv
// Types and constants shared by the pressure report trigger.
package prt_pkg;

  localparam int PRES_W   = 16;
  localparam int VBAT_W   = 10;
  localparam int DTHR_W   = 12;
  localparam int CNT_W    = 8;
  localparam int HB_W     = 16;
  localparam int NEAR_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int FAIL_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_TICK = 2'd0;
  localparam func_t FUNC_KEY  = 2'd1;
  localparam func_t FUNC_SEND = 2'd2;

  typedef logic [1:0] cause_t;
  localparam cause_t CAUSE_RESET = 2'd0;
  localparam cause_t CAUSE_DELTA = 2'd1;
  localparam cause_t CAUSE_TIMER = 2'd2;
  localparam cause_t CAUSE_KEY   = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DELTA_THR  = 3'd0;
  localparam cfg_idx_t REG_VBAT_THR   = 3'd1;
  localparam cfg_idx_t REG_HB_TICKS   = 3'd2;
  localparam cfg_idx_t REG_LOW_LIMIT  = 3'd3;
  localparam cfg_idx_t REG_OK_LIMIT   = 3'd4;
  localparam cfg_idx_t REG_NEAR_LIMIT = 3'd5;
  localparam cfg_idx_t REG_SLOW_PER   = 3'd6;
  localparam cfg_idx_t REG_NORM_PER   = 3'd7;

  localparam logic [DTHR_W-1:0]   RST_DELTA_THR  = 12'd20;
  localparam logic [VBAT_W-1:0]   RST_VBAT_THR   = 10'd340;
  localparam logic [HB_W-1:0]     RST_HB_TICKS   = 16'd330;
  localparam logic [CNT_W-1:0]    RST_LOW_LIMIT  = 8'd30;
  localparam logic [CNT_W-1:0]    RST_OK_LIMIT   = 8'd6;
  localparam logic [NEAR_W-1:0]   RST_NEAR_LIMIT = 4'd3;
  localparam logic [PERIOD_W-1:0] RST_SLOW_PER   = 16'd54;
  localparam logic [PERIOD_W-1:0] RST_NORM_PER   = 16'd20;
  localparam logic [PERIOD_W-1:0] BOOT_PERIOD    = 16'd18;

endpackage

FILE: src/pressure_report_trigger.sv
// Top level: report request logic for a battery-powered pressure node.
// Each input word is one event (sample tick, key press or send done) and yields
// one output word showing the request state after that event. A word is held in
// the input register and is evaluated against the state registers on the way
// into the output register, and one word is taken every cycle; the output
// register decouples the two channels, and the input stalls only while the
// output word is held back.
`include "pressure_report_trigger_macros.svh"

module pressure_report_trigger (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  prt_pkg::func_t                      in_func,
  input  logic signed [prt_pkg::PRES_W-1:0]   in_pressure,
  input  logic [prt_pkg::VBAT_W-1:0]          in_vbat,
  input  logic                                in_key_level,
  input  logic                                in_send_ok,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_push_pending,
  output prt_pkg::cause_t                     out_report_cause,
  output logic [prt_pkg::PERIOD_W-1:0]        out_wake_period,
  output logic [prt_pkg::FAIL_W-1:0]          out_error_count,
  input  logic                                cfg_we,
  input  prt_pkg::cfg_idx_t                   cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import prt_pkg::*;

  // configuration
  logic [DTHR_W-1:0]   delta_thr_r;
  logic [VBAT_W-1:0]   vbat_thr_r;
  logic [HB_W-1:0]     hb_ticks_r;
  logic [CNT_W-1:0]    low_limit_r;
  logic [CNT_W-1:0]    ok_limit_r;
  logic [NEAR_W-1:0]   near_limit_r;
  logic [PERIOD_W-1:0] slow_per_r;
  logic [PERIOD_W-1:0] norm_per_r;

  // input register
  logic                     in_vld_r;
  func_t                    func_r;
  logic signed [PRES_W-1:0] pres_r;
  logic [VBAT_W-1:0]        vbat_r;
  logic                     key_r;
  logic                     ok_r;

  // node state
  logic signed [PRES_W-1:0] ref_r,    ref_nxt;
  logic [CNT_W-1:0]         low_r,    low_nxt;
  logic [CNT_W-1:0]         good_r,   good_nxt;
  logic [HB_W-1:0]          hb_r,     hb_nxt;
  logic [NEAR_W-1:0]        near_r,   near_nxt;
  logic                     req_r,    req_nxt;
  cause_t                   cause_r,  cause_nxt;
  logic [FAIL_W-1:0]        fail_r,   fail_nxt;
  logic [PERIOD_W-1:0]      period_r, period_nxt;

  // output register
  logic                out_vld_r;
  logic                out_push_r;
  cause_t              out_cause_r;
  logic [PERIOD_W-1:0] out_period_r;
  logic [FAIL_W-1:0]   out_err_r;

  logic                   advance;
  logic signed [PRES_W:0] diff;
  logic [PRES_W-1:0]      dp;
  logic [PRES_W:0]        dp2;
  logic [CNT_W-1:0]       low_inc, good_inc;
  logic [HB_W-1:0]        hb_inc;
  logic [NEAR_W-1:0]      near_inc;
  logic [FAIL_W-1:0]      fail_inc;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign diff = {pres_r[PRES_W-1], pres_r} - {ref_r[PRES_W-1], ref_r};
  // magnitude never exceeds 65535
  assign dp   = diff[PRES_W] ? PRES_W'(-diff) : diff[PRES_W-1:0];
  assign dp2  = {dp, 1'b0};

  assign low_inc  = (low_r  == '1) ? low_r  : low_r  + CNT_W'(1);
  assign good_inc = (good_r == '1) ? good_r : good_r + CNT_W'(1);
  assign hb_inc   = (hb_r   == '1) ? hb_r   : hb_r   + HB_W'(1);
  assign near_inc = (near_r == '1) ? near_r : near_r + NEAR_W'(1);
  assign fail_inc = (fail_r == '1) ? fail_r : fail_r + FAIL_W'(1);

  always_comb begin
    ref_nxt    = ref_r;
    low_nxt    = low_r;
    good_nxt   = good_r;
    hb_nxt     = hb_r;
    near_nxt   = near_r;
    req_nxt    = req_r;
    cause_nxt  = cause_r;
    fail_nxt   = fail_r;
    period_nxt = period_r;
    case (func_r)
      FUNC_TICK: begin
        if (key_r) begin
          if (vbat_r <= vbat_thr_r) begin
            low_nxt  = low_inc;
            good_nxt = '0;
            if (low_inc >= low_limit_r) begin
              low_nxt    = '0;
              period_nxt = slow_per_r;
            end
          end else begin
            good_nxt = good_inc;
            low_nxt  = '0;
            if (good_inc >= ok_limit_r) begin
              good_nxt   = '0;
              period_nxt = norm_per_r;
            end
          end
          hb_nxt = hb_inc;
          if (hb_inc >= hb_ticks_r) begin
            req_nxt   = 1'b1;
            cause_nxt = CAUSE_TIMER;
            hb_nxt    = '0;
            fail_nxt  = '0;
          end
          if (dp >= PRES_W'(delta_thr_r)) begin
            req_nxt   = 1'b1;
            cause_nxt = CAUSE_DELTA;
            near_nxt  = '0;
          end else if (dp2 >= (PRES_W+1)'(delta_thr_r)) begin
            near_nxt = near_inc;
            if (near_inc >= near_limit_r) begin
              req_nxt   = 1'b1;
              cause_nxt = CAUSE_DELTA;
              near_nxt  = '0;
            end
          end else begin
            near_nxt = '0;
          end
        end
      end
      FUNC_KEY: begin
        req_nxt   = 1'b1;
        cause_nxt = CAUSE_KEY;
      end
      FUNC_SEND: begin
        if (req_r) begin
          req_nxt = 1'b0;
          if (ok_r) begin
            ref_nxt = pres_r;
          end else begin
            fail_nxt = fail_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_thr_r  <= RST_DELTA_THR;
      vbat_thr_r   <= RST_VBAT_THR;
      hb_ticks_r   <= RST_HB_TICKS;
      low_limit_r  <= RST_LOW_LIMIT;
      ok_limit_r   <= RST_OK_LIMIT;
      near_limit_r <= RST_NEAR_LIMIT;
      slow_per_r   <= RST_SLOW_PER;
      norm_per_r   <= RST_NORM_PER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELTA_THR:  delta_thr_r  <= cfg_wdata[DTHR_W-1:0];
        REG_VBAT_THR:   vbat_thr_r   <= cfg_wdata[VBAT_W-1:0];
        REG_HB_TICKS:   hb_ticks_r   <= cfg_wdata[HB_W-1:0];
        REG_LOW_LIMIT:  low_limit_r  <= cfg_wdata[CNT_W-1:0];
        REG_OK_LIMIT:   ok_limit_r   <= cfg_wdata[CNT_W-1:0];
        REG_NEAR_LIMIT: near_limit_r <= cfg_wdata[NEAR_W-1:0];
        REG_SLOW_PER:   slow_per_r   <= cfg_wdata[PERIOD_W-1:0];
        REG_NORM_PER:   norm_per_r   <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r <= in_func;
      pres_r <= in_pressure;
      vbat_r <= in_vbat;
      key_r  <= in_key_level;
      ok_r   <= in_send_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= '0;
      low_r    <= '0;
      good_r   <= '0;
      hb_r     <= '0;
      near_r   <= '0;
      req_r    <= 1'b0;
      cause_r  <= CAUSE_RESET;
      fail_r   <= '0;
      period_r <= BOOT_PERIOD;
    end else if (advance) begin
      ref_r    <= ref_nxt;
      low_r    <= low_nxt;
      good_r   <= good_nxt;
      hb_r     <= hb_nxt;
      near_r   <= near_nxt;
      req_r    <= req_nxt;
      cause_r  <= cause_nxt;
      fail_r   <= fail_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_push_r   <= req_nxt;
      out_cause_r  <= cause_nxt;
      out_period_r <= period_nxt;
      out_err_r    <= fail_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_push_pending = out_push_r;
  assign out_report_cause = out_cause_r;
  assign out_wake_period  = out_period_r;
  assign out_error_count  = out_err_r;

  `PRT_ASSERT_IMP(a_stall_cause, !in_ready, in_vld_r && out_vld_r && !out_ready, "input stalled without output backpressure")
  `PRT_ASSERT_NXT(a_adv_out, advance, out_vld_r, "evaluated word not presented")
  `PRT_ASSERT_IMP(a_req_cause, $rose(req_r), cause_r != CAUSE_RESET, "request raised without cause")
  `PRT_ASSERT_NXT(a_out_state, advance, out_push_r == req_r && out_err_r == fail_r && out_period_r == period_r, "output word differs from state")

endmodule
